/* hw/rtl/ccr_pkg.sv */
// ----------------------------------------------------------------------------
// ccr_pkg: shared types and constants of the contrast ratio block
// sRGB linearization table, luminance weights and datapath widths.
// ----------------------------------------------------------------------------
package ccr_pkg;

	localparam int CH_W      = 8;
	localparam int RGB_W     = 3 * CH_W;
	localparam int CHANNELS  = 3;
	localparam int CODES     = 1 << CH_W;
	localparam int LIN_FRAC  = 16;
	// table entries reach 1.0, so one bit above the fraction
	localparam int TAB_W     = LIN_FRAC + 1;
	localparam int WEIGHT_W  = 16;
	// q0.32 luminance plus offset, up to 2^32 + offset
	localparam int LUM_W     = 2 * LIN_FRAC + 1;
	localparam int RATIO_INT_BITS = 5;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [WEIGHT_W-1:0] W_R = 16'd13933;
	localparam logic [WEIGHT_W-1:0] W_G = 16'd46871;
	localparam logic [WEIGHT_W-1:0] W_B = 16'd4732;
	localparam logic [WEIGHT_W-1:0] WEIGHTS [CHANNELS] = '{W_R, W_G, W_B};

	localparam logic [WEIGHT_W-1:0] OFFSET_Q16 = 16'd3277;
	localparam logic [LUM_W-1:0] OFFSET_Q32 = LUM_W'(OFFSET_Q16) << LIN_FRAC;
	localparam logic [LUM_W-1:0] LUM_MAX = (LUM_W'(1) << (2 * LIN_FRAC)) + OFFSET_Q32;

	typedef logic [CODES-1:0][TAB_W-1:0] lin_tab_t;

	localparam int BIG_W        = 256;
	localparam int SEARCH_W     = TAB_W + 1;
	localparam int SEARCH_STEPS = 17;

	// bright codes: largest y with (2y-1)^5 * 10761^12 <= 2^85 * (40c+561)^12
	// dark codes: c/255/12.92 rounded half up
	function automatic lin_tab_t build_lin_tab();
		lin_tab_t             tab;
		logic [BIG_W-1:0]     d12;
		logic [BIG_W-1:0]     rhs;
		logic [BIG_W-1:0]     lhs;
		logic [SEARCH_W-1:0]  lo;
		logic [SEARCH_W-1:0]  hi;
		logic [SEARCH_W-1:0]  mid;
		int unsigned          code;
		int unsigned          k;
		int unsigned          j;
		d12 = BIG_W'(1);
		for (k = 0; k < 12; k++) begin
			d12 = d12 * BIG_W'(10761);
		end
		for (code = 0; code < CODES; code++) begin
			if (code * 100000 < 3928 * 255) begin
				tab[code] = TAB_W'((6553600 * code + 164730) / 329460);
			end else begin
				lo  = '0;
				hi  = SEARCH_W'(65536);
				rhs = BIG_W'(1);
				for (k = 0; k < 12; k++) begin
					rhs = rhs * BIG_W'(40 * code + 561);
				end
				for (k = 0; k < 5; k++) begin
					rhs = rhs * BIG_W'(131072);
				end
				for (k = 0; k < SEARCH_STEPS; k++) begin
					if (lo < hi) begin
						mid = SEARCH_W'((lo + hi + 1) >> 1);
						lhs = d12;
						for (j = 0; j < 5; j++) begin
							lhs = lhs * BIG_W'(2 * mid - 1);
						end
						if (lhs <= rhs) begin
							lo = mid;
						end else begin
							hi = mid - 1'b1;
						end
					end
				end
				tab[code] = lo[TAB_W-1:0];
			end
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

/* hw/rtl/ccr_if.sv */
// ----------------------------------------------------------------------------
// ccr_if: valid/ready channels of the contrast ratio block
// Color pair input, ratio output, and the luminance pair link inside.
// ----------------------------------------------------------------------------
interface ccr_color_if import ccr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RGB_W-1:0] background_rgb;
	logic [RGB_W-1:0] foreground_rgb;

	modport source (output valid, output background_rgb, output foreground_rgb, input ready);
	modport sink   (input valid, input background_rgb, input foreground_rgb, output ready);
endinterface

interface ccr_ratio_if import ccr_pkg::*; #(parameter int FRACTION_BITS = 16) ();
	logic                                    valid;
	logic                                    ready;
	logic [RATIO_INT_BITS+FRACTION_BITS-1:0] contrast_ratio;

	modport source (output valid, output contrast_ratio, input ready);
	modport sink   (input valid, input contrast_ratio, output ready);
endinterface

interface ccr_lum_if import ccr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LUM_W-1:0] bg_lum;
	logic [LUM_W-1:0] fg_lum;

	modport source (output valid, output bg_lum, output fg_lum, input ready);
	modport sink   (input valid, input bg_lum, input fg_lum, output ready);
endinterface

/* hw/rtl/ccr_front.sv */
// ----------------------------------------------------------------------------
// ccr_front: luminance front end
// Table lookup, weighting and offset add over three pipeline stages.
// ----------------------------------------------------------------------------
module ccr_front import ccr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ccr_color_if.sink    colors,
	ccr_lum_if.source    lum
);

	logic             en;
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic [TAB_W-1:0] lin_bg;
	logic [TAB_W-1:0] lin_fg;
	logic [TAB_W-1:0] lin_bg_s1 [CHANNELS];
	logic [TAB_W-1:0] lin_fg_s1 [CHANNELS];
	logic [LUM_W-1:0] prod_bg_s2 [CHANNELS];
	logic [LUM_W-1:0] prod_fg_s2 [CHANNELS];
	logic [LUM_W-1:0] lum_bg_s3;
	logic [LUM_W-1:0] lum_fg_s3;

	// whole front moves together unless its last stage is held
	assign en           = !v_s3 || lum.ready;
	assign colors.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= colors.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// red from the top byte, blue from the bottom
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				lin_bg_s1[ch] <= LIN_TAB[colors.background_rgb[CH_W*(CHANNELS-1-ch) +: CH_W]];
				lin_fg_s1[ch] <= LIN_TAB[colors.foreground_rgb[CH_W*(CHANNELS-1-ch) +: CH_W]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				prod_bg_s2[ch] <= LUM_W'(WEIGHTS[ch]) * LUM_W'(lin_bg_s1[ch]);
				prod_fg_s2[ch] <= LUM_W'(WEIGHTS[ch]) * LUM_W'(lin_fg_s1[ch]);
			end
		end
	end

	// weights sum to one, so the total stays within 2^32 plus offset
	always_ff @(posedge clk) begin
		if (en) begin
			lum_bg_s3 <= prod_bg_s2[0] + prod_bg_s2[1] + prod_bg_s2[2] + OFFSET_Q32;
			lum_fg_s3 <= prod_fg_s2[0] + prod_fg_s2[1] + prod_fg_s2[2] + OFFSET_Q32;
		end
	end

	assign lin_bg     = lin_bg_s1[0];
	assign lin_fg     = lin_fg_s1[0];
	assign lum.valid  = v_s3;
	assign lum.bg_lum = lum_bg_s3;
	assign lum.fg_lum = lum_fg_s3;

`ifndef SYNTHESIS
	a_lum_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (lum_bg_s3 >= OFFSET_Q32 && lum_bg_s3 <= LUM_MAX &&
			lum_fg_s3 >= OFFSET_Q32 && lum_fg_s3 <= LUM_MAX))
		else $error("luminance out of range");
	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (lin_bg <= (TAB_W'(1) << LIN_FRAC) && lin_fg <= (TAB_W'(1) << LIN_FRAC)))
		else $error("linear value above one");
`endif

endmodule

/* hw/rtl/ccr_queue.sv */
// ----------------------------------------------------------------------------
// ccr_queue: luminance pair queue
// Small fifo that decouples the front end from the divider.
// ----------------------------------------------------------------------------
module ccr_queue import ccr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ccr_lum_if.sink    push,
	ccr_lum_if.source  pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [LUM_W-1:0] bg_q [QUEUE_DEPTH];
	logic [LUM_W-1:0] fg_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push.ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop.valid  = (count_q != '0);
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;
	assign pop.bg_lum = bg_q[rd_ptr_q];
	assign pop.fg_lum = fg_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			bg_q[wr_ptr_q] <= push.bg_lum;
			fg_q[wr_ptr_q] <= push.fg_lum;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count not lowered on pop");
`endif

endmodule

/* hw/rtl/ccr_divider.sv */
// ----------------------------------------------------------------------------
// ccr_divider: pipelined ratio divider
// Restoring division, one quotient bit per stage, last stage is the output.
// ----------------------------------------------------------------------------
module ccr_divider import ccr_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ccr_lum_if.sink     lum,
	ccr_ratio_if.source ratio
);

	localparam int QW = RATIO_INT_BITS + FRACTION_BITS;

	logic             en;
	logic             val_in [QW];
	logic [LUM_W-1:0] rem_in [QW];
	logic [LUM_W-1:0] div_in [QW];
	logic [QW-1:0]    nb_in  [QW];
	logic [QW-1:0]    quo_in [QW];
	// one entry per stage
	logic             valid_s [QW];
	logic [LUM_W-1:0] rem_s   [QW];
	logic [LUM_W-1:0] div_s   [QW];
	logic [QW-1:0]    nb_s    [QW];
	logic [QW-1:0]    quo_s   [QW];

	assign en        = !valid_s[QW-1] || ratio.ready;
	assign lum.ready = en;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [LUM_W:0] trial;
		logic           take;

		if (k == 0) begin : g_head
			// quotient fits in QW bits, so the dividend top part starts below the divisor
			assign val_in[k] = lum.valid;
			assign rem_in[k] = lum.fg_lum >> RATIO_INT_BITS;
			assign div_in[k] = lum.bg_lum;
			assign nb_in[k]  = {lum.fg_lum[RATIO_INT_BITS-1:0], {FRACTION_BITS{1'b0}}};
			assign quo_in[k] = '0;
		end else begin : g_link
			assign val_in[k] = valid_s[k-1];
			assign rem_in[k] = rem_s[k-1];
			assign div_in[k] = div_s[k-1];
			assign nb_in[k]  = nb_s[k-1];
			assign quo_in[k] = quo_s[k-1];
		end

		assign trial = {rem_in[k], nb_in[k][QW-1]};
		assign take  = (trial >= {1'b0, div_in[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= val_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? LUM_W'(trial - {1'b0, div_in[k]}) : trial[LUM_W-1:0];
				div_s[k] <= div_in[k];
				nb_s[k]  <= {nb_in[k][QW-2:0], 1'b0};
				quo_s[k] <= {quo_in[k][QW-2:0], take};
			end
		end
	end

	assign ratio.valid          = valid_s[QW-1];
	assign ratio.contrast_ratio = quo_s[QW-1];

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[QW-1] |-> rem_s[QW-1] < div_s[QW-1])
		else $error("division remainder not below divisor");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(lum.valid && lum.ready) |=> valid_s[0])
		else $error("accepted pair missing from first divider stage");
`endif

endmodule

/* hw/rtl/color_contrast_ratio.sv */
// ----------------------------------------------------------------------------
// color_contrast_ratio: wcag contrast ratio of two sRGB colors
// Front end computes both luminances, a queue feeds the pipelined divider.
// ----------------------------------------------------------------------------
// Takes one background/foreground pair of 24-bit colors per item and returns
// (fgL + 0.05) / (bgL + 0.05) as unsigned Q5.FRACTION_BITS, truncated, with no
// swap when the foreground is darker. One item is taken every cycle as long as
// the result side keeps up; the rate is set by the divider, which is fully
// pipelined with one quotient bit per stage, and by the front end, which reads
// the 256-entry linearization table, weights and sums in three stages.
// An accepted pair passes three front stages, the queue storage and
// 5 + FRACTION_BITS divider stages on its way to the result. A four-entry
// queue sits between front and divider, so a stalled result side holds the
// divider while the front end keeps accepting until the queue fills. Alpha
// bits are not part of the port.
module color_contrast_ratio #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ccr_color_if.sink   colors,
	ccr_ratio_if.source ratio
);

	// luminance pairs from the front end, and from the queue to the divider
	ccr_lum_if front_lum ();
	ccr_lum_if back_lum ();

	ccr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.colors (colors),
		.lum    (front_lum)
	);

	ccr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_lum),
		.pop    (back_lum)
	);

	ccr_divider #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.lum    (back_lum),
		.ratio  (ratio)
	);

endmodule

/* bench/tb_color_contrast_ratio.sv */
// ----------------------------------------------------------------------------
// tb_color_contrast_ratio: self-checking bench of the contrast ratio block
// Streams background/foreground color pairs through the block and checks each
// ratio against a bit-exact predictor that builds its own linearization table
// with wide integer arithmetic. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_color_contrast_ratio import ccr_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC      = 16;
	localparam int RATIO_W   = RATIO_INT_BITS + FRAC;
	// accepted pair to result: front stages, queue storage and divider stages
	localparam int LATENCY   = 9 + FRAC;
	localparam int SETTLE    = LATENCY + 16;
	localparam int IDLE_PCT  = 34;
	localparam int HOLD_LONG = 160;

	// bt.709 weights in q0.16 and the 0.05 flare term
	localparam logic [63:0] WEIGHT_RED   = 64'd13933;
	localparam logic [63:0] WEIGHT_GREEN = 64'd46871;
	localparam logic [63:0] WEIGHT_BLUE  = 64'd4732;
	localparam logic [63:0] FLARE_Q32    = 64'd3277 << 16;

	logic clk;
	logic arst_n;

	ccr_color_if                         colors_if ();
	ccr_ratio_if #(.FRACTION_BITS(FRAC)) ratio_if ();

	color_contrast_ratio #(
		.FRACTION_BITS(FRAC)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.colors(colors_if),
		.ratio (ratio_if)
	);

	// predictor state: srgb code to linear light, q0.16 with 1.0 reachable
	logic [TAB_W-1:0]   srgb_to_linear [CODES];
	logic [RATIO_W-1:0] pending_ratios [$];
	int unsigned        error_count;

	// knobs shared by the test tasks, send_pair and the ready driver process
	bit          sender_gaps;
	bit          receiver_gaps;
	int unsigned hold_request;

	// ------------------------------------------------------------------------
	// clock, reset and time limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// dark codes follow the linear toe, rounded half up; bright codes are the
	// largest y with (2y-1)^5 * 10761^12 <= 2^85 * (40c+561)^12, found by
	// successive approximation over the 17 bits of y
	function automatic void build_srgb_to_linear();
		logic [255:0] knee_pow;
		logic [255:0] bound;
		logic [255:0] lhs;
		logic [255:0] odd;
		int unsigned  code;
		int unsigned  guess;
		int unsigned  trial;
		int           bit_pos;
		knee_pow = 256'd1;
		repeat (12) knee_pow = knee_pow * 256'd10761;
		for (code = 0; code < CODES; code++) begin
			if (code * 100000 < 3928 * 255) begin
				srgb_to_linear[code] = TAB_W'((6553600 * code + 164730) / 329460);
			end else begin
				bound = 256'd1;
				repeat (12) bound = bound * 256'(40 * code + 561);
				bound = bound << 85;
				guess = 0;
				for (bit_pos = 16; bit_pos >= 0; bit_pos--) begin
					trial = guess | (32'd1 << bit_pos);
					if (trial <= 65536) begin
						odd = 256'(2 * trial - 1);
						lhs = knee_pow;
						repeat (5) lhs = lhs * odd;
						if (lhs <= bound) begin
							guess = trial;
						end
					end
				end
				srgb_to_linear[code] = TAB_W'(guess);
			end
		end
	endfunction

	// q0.32 relative luminance plus flare
	function automatic logic [63:0] lit_luminance(logic [RGB_W-1:0] rgb);
		return WEIGHT_RED   * 64'(srgb_to_linear[rgb[23:16]])
		     + WEIGHT_GREEN * 64'(srgb_to_linear[rgb[15:8]])
		     + WEIGHT_BLUE  * 64'(srgb_to_linear[rgb[7:0]])
		     + FLARE_Q32;
	endfunction

	// no swap: a darker foreground gives a ratio below one
	function automatic logic [RATIO_W-1:0] predict_ratio(logic [RGB_W-1:0] bg,
	                                                     logic [RGB_W-1:0] fg);
		logic [63:0] quotient;
		quotient = (lit_luminance(fg) << FRAC) / lit_luminance(bg);
		return quotient[RATIO_W-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// result side: ready pattern and checker
	// ------------------------------------------------------------------------

	// a hold request is taken over and counted down here, cycle by cycle
	initial begin : ready_driver
		int unsigned hold_left;
		hold_left = 0;
		ratio_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (!arst_n) begin
				ratio_if.ready <= 1'b0;
			end else if (hold_left != 0) begin
				ratio_if.ready <= 1'b0;
				hold_left--;
			end else if (!receiver_gaps) begin
				ratio_if.ready <= 1'b1;
			end else begin
				ratio_if.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic report_mismatch(string what, logic [RATIO_W-1:0] got,
	                               logic [RATIO_W-1:0] want);
		error_count++;
		$display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// values read right after the edge are the ones the edge saw
	always @(posedge clk) begin
		logic [RATIO_W-1:0] want;
		if (arst_n && ratio_if.valid && ratio_if.ready) begin
			if (pending_ratios.size() == 0) begin
				report_mismatch("result with no pair waiting", ratio_if.contrast_ratio, '0);
			end else begin
				want = pending_ratios.pop_front();
				if (ratio_if.contrast_ratio !== want) begin
					report_mismatch("contrast_ratio", ratio_if.contrast_ratio, want);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// color side: one item per call, valid kept high across back-to-back items
	// ------------------------------------------------------------------------
	task automatic send_pair(logic [RGB_W-1:0] bg, logic [RGB_W-1:0] fg);
		while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
			colors_if.valid          <= 1'b0;
			colors_if.background_rgb <= RGB_W'($urandom);
			colors_if.foreground_rgb <= RGB_W'($urandom);
			@(posedge clk);
		end
		colors_if.valid          <= 1'b1;
		colors_if.background_rgb <= bg;
		colors_if.foreground_rgb <= fg;
		@(posedge clk);
		while (!colors_if.ready) @(posedge clk);
		pending_ratios.push_back(predict_ratio(bg, fg));
	endtask

	// sender pauses until every expected ratio is back
	task automatic wait_for_ratios();
		colors_if.valid <= 1'b0;
		while (pending_ratios.size() != 0) @(posedge clk);
	endtask

	function automatic logic [RGB_W-1:0] grey(logic [7:0] code);
		return {code, code, code};
	endfunction

	// channel codes biased toward the ends and the toe/curve boundary
	function automatic logic [7:0] pick_code();
		case ($urandom_range(7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'(9 + $urandom_range(3));
			default: return 8'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// black, white, primaries, toe boundary, ratio below one and at maximum
	task automatic test_extremes();
		send_pair(24'h000000, 24'hFFFFFF);  // largest ratio
		send_pair(24'hFFFFFF, 24'h000000);  // smallest ratio, not swapped
		send_pair(24'h000000, 24'h000000);
		send_pair(24'hFFFFFF, 24'hFFFFFF);
		send_pair(24'h000000, 24'hFF0000);
		send_pair(24'h000000, 24'h00FF00);
		send_pair(24'h000000, 24'h0000FF);
		send_pair(24'hFF0000, 24'h000000);
		send_pair(24'h00FF00, 24'h000000);
		send_pair(24'h0000FF, 24'h000000);
		send_pair(24'h00FF00, 24'hFF00FF);
		send_pair(24'hFF00FF, 24'h00FF00);
		// last dark code and first bright code of the curve
		send_pair(24'h000000, grey(8'd10));
		send_pair(24'h000000, grey(8'd11));
		send_pair(grey(8'd10), grey(8'd11));
		send_pair(grey(8'd11), grey(8'd10));
		send_pair(grey(8'd1), 24'h000000);
		send_pair(grey(8'd254), 24'hFFFFFF);
		send_pair(24'hAAAAAA, 24'h555555);
		send_pair(24'h555555, 24'hAAAAAA);
		send_pair(24'h808080, 24'h808080);
		wait_for_ratios();
	endtask

	// every table entry, odd codes as background and even codes as foreground
	task automatic test_code_sweep();
		int unsigned code;
		for (code = 0; code < CODES; code++) begin
			if (code[0]) begin
				send_pair(grey(8'(code)), RGB_W'($urandom));
			end else begin
				send_pair(RGB_W'($urandom), grey(8'(code)));
			end
		end
	endtask

	task automatic test_random_pairs(int unsigned count);
		int unsigned n;
		logic [RGB_W-1:0] bg;
		logic [RGB_W-1:0] fg;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(3) == 0) begin
				bg = {pick_code(), pick_code(), pick_code()};
				fg = {pick_code(), pick_code(), pick_code()};
			end else begin
				bg = RGB_W'($urandom);
				fg = RGB_W'($urandom);
			end
			send_pair(bg, fg);
		end
	endtask

	// full rate on both sides for a long stretch
	task automatic test_back_to_back(int unsigned count);
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		test_random_pairs(count);
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	// result side held off while pairs keep coming, so the queue fills and
	// the color side backs up
	task automatic test_output_stall(int unsigned count);
		wait_for_ratios();
		sender_gaps  = 1'b0;
		hold_request = HOLD_LONG;
		test_random_pairs(count);
		sender_gaps  = 1'b1;
		wait_for_ratios();
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n                   = 1'b0;
		colors_if.valid          = 1'b0;
		colors_if.background_rgb = '0;
		colors_if.foreground_rgb = '0;
		error_count              = 0;
		sender_gaps              = 1'b1;
		receiver_gaps            = 1'b1;
		hold_request             = 0;
		build_srgb_to_linear();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_code_sweep();
		test_random_pairs(450);
		test_back_to_back(220);
		test_output_stall(60);
		test_random_pairs(450);

		wait_for_ratios();
		// anything that still comes out now has no pair behind it
		repeat (SETTLE) @(posedge clk);

		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/ccr_pkg.sv
hw/rtl/ccr_if.sv
hw/rtl/ccr_front.sv
hw/rtl/ccr_queue.sv
hw/rtl/ccr_divider.sv
hw/rtl/color_contrast_ratio.sv
bench/tb_color_contrast_ratio.sv
